[rtl/bmf_pkg.sv]
// Shared types and constants for the 3x3 box-mean filter.
// No dependencies; used by bmf_line_buf and box_mean_3x3_filter.
`timescale 1ns / 1ps

package bmf_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int POS_BITS       = 11;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 11;
  localparam int HEIGHT_LIMIT   = 1024;
  localparam int RESET_SIZE     = 1024;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  // floor(y/3) = (y * RECIP3) >> RECIP3_SHIFT, floor(y/9) likewise, exact for y < 2^19
  localparam logic [19:0] RECIP3       = 20'd699051;
  localparam int          RECIP3_SHIFT = 21;
  localparam logic [19:0] RECIP9       = 20'd932068;
  localparam int          RECIP9_SHIFT = 23;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } lb_ctl_t;

  typedef struct packed {
    logic left;
    logic right;
    logic up;
    logic down;
    logic last;
  } pos_flags_t;

endpackage

[rtl/bmf_line_buf.sv]
// Two row stores for the box-mean filter, registered read with write bypass.
// Depends on bmf_pkg.
`timescale 1ns / 1ps

module bmf_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  bmf_pkg::lb_ctl_t ctl,
  input  logic [AW-1:0]    rd_addr,
  input  logic [AW-1:0]    wr_addr,
  input  bmf_pkg::sample_t wr_upper,
  input  bmf_pkg::sample_t wr_lower,
  output bmf_pkg::sample_t rd_upper,
  output bmf_pkg::sample_t rd_lower
);

  bmf_pkg::sample_t upper_mem [DEPTH];
  bmf_pkg::sample_t lower_mem [DEPTH];
  bmf_pkg::sample_t rd_upper_r;
  bmf_pkg::sample_t rd_lower_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      upper_mem[wr_addr] <= wr_upper;
      lower_mem[wr_addr] <= wr_lower;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      if (ctl.wr_en && (wr_addr == rd_addr)) begin
        rd_upper_r <= wr_upper;
        rd_lower_r <= wr_lower;
      end else begin
        rd_upper_r <= upper_mem[rd_addr];
        rd_lower_r <= lower_mem[rd_addr];
      end
    end
  end

  assign rd_upper = rd_upper_r;
  assign rd_lower = rd_lower_r;

endmodule

[rtl/box_mean_3x3_filter.sv]
// Streaming 3x3 box-mean filter over raster-order samples; depends on bmf_pkg, bmf_line_buf.
// Throughput: one item per clock unless out_ready stalls, set by the row stores (one read,
// one write per clock). Item k+W+1 completes pixel k; its mean passes A, B, C, D, out.
// Flush items in the pixel phase are taken and dropped; W+1 flush items drain a frame.
// Reset: width and height 1024 (width capped at MAX_WIDTH), counters and window zero,
// pipeline empty; row stores are not cleared.
`timescale 1ns / 1ps

module box_mean_3x3_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic signed [15:0]                   in_pixel_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   out_mean_value,
  output logic                                 out_frame_last,
  input  logic                                 cfg_wr_en,
  input  logic [bmf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bmf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam bmf_pkg::pos_t WIDTH_RESET = bmf_pkg::POS_BITS'(
      (MAX_WIDTH < bmf_pkg::RESET_SIZE) ? MAX_WIDTH : bmf_pkg::RESET_SIZE);
  localparam bmf_pkg::pos_t HEIGHT_RESET = bmf_pkg::POS_BITS'(bmf_pkg::RESET_SIZE);

  // configuration
  bmf_pkg::pos_t frame_width_r;
  bmf_pkg::pos_t frame_height_r;
  bmf_pkg::pos_t cfg_val;
  bmf_pkg::pos_t width_clamped;
  bmf_pkg::pos_t height_clamped;

  // position counters
  bmf_pkg::pos_t in_col_r, in_col_nxt;
  bmf_pkg::pos_t in_row_r, in_row_nxt;
  bmf_pkg::pos_t out_col_r, out_col_nxt;
  bmf_pkg::pos_t out_row_r, out_row_nxt;
  bmf_pkg::pos_t col_inc;
  bmf_pkg::pos_t out_col_inc;

  logic in_xfer;
  logic pixel_phase;
  logic keep;
  logic emit;
  bmf_pkg::pos_flags_t cur_flags;

  // pipeline handshake
  logic out_free, d_free, c_free, b_free, a_free, a_move;

  // stage A: accepted item
  logic                a_valid_r;
  bmf_pkg::sample_t    a_sample_r;
  logic [AW-1:0]       a_col_r;
  logic                a_emit_r;
  bmf_pkg::pos_flags_t a_flags_r;

  // row stores
  bmf_pkg::lb_ctl_t lb_ctl;
  bmf_pkg::sample_t lb_rd_upper;
  bmf_pkg::sample_t lb_rd_lower;

  // window and stage B
  bmf_pkg::sample_t [2:0][2:0] win_r;
  logic                b_valid_r;
  bmf_pkg::pos_flags_t b_flags_r;
  logic signed [17:0]  row_sum [3];

  // stage C: row sums
  logic                c_valid_r;
  logic signed [17:0]  c_row_r [3];
  bmf_pkg::pos_flags_t c_flags_r;
  logic signed [19:0]  total;
  logic [18:0]         mag;
  logic [1:0]          n_rows;
  logic [1:0]          n_cols;
  logic [3:0]          n_cnt;
  logic [19:0]         x_val;
  logic [18:0]         y_val;

  // stage D: scaled magnitude
  logic                d_valid_r;
  logic [18:0]         d_y_r;
  logic [3:0]          d_n_r;
  logic                d_neg_r;
  logic                d_last_r;
  logic [19:0]         mult;
  logic [4:0]          sh;
  logic [38:0]         prod;
  logic [16:0]         q_val;
  logic [16:0]         mean_val;

  // output register
  logic                out_valid_r;
  bmf_pkg::sample_t    out_mean_value_r;
  logic                out_frame_last_r;

  // ---------------------------------------------------------------- config
  always_comb begin
    cfg_val        = (cfg_data == '0) ? bmf_pkg::POS_BITS'(1) : cfg_data;
    width_clamped  = (32'(cfg_val) > 32'(MAX_WIDTH)) ? bmf_pkg::POS_BITS'(MAX_WIDTH) : cfg_val;
    height_clamped = (32'(cfg_val) > 32'(bmf_pkg::HEIGHT_LIMIT)) ?
                     bmf_pkg::POS_BITS'(bmf_pkg::HEIGHT_LIMIT) : cfg_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bmf_pkg::REG_FRAME_WIDTH:  frame_width_r  <= width_clamped;
        bmf_pkg::REG_FRAME_HEIGHT: frame_height_r <= height_clamped;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  assign out_free = !out_valid_r || out_ready;
  assign d_free   = !d_valid_r || out_free;
  assign c_free   = !c_valid_r || d_free;
  assign b_free   = !b_valid_r || c_free;
  assign a_free   = !a_valid_r || b_free;
  assign a_move   = a_valid_r && b_free;
  assign in_ready = a_free;
  assign in_xfer  = in_valid && a_free;

  // ---------------------------------------------------------------- counters
  always_comb begin
    pixel_phase     = in_row_r < frame_height_r;
    keep            = in_xfer && !(pixel_phase && in_action);
    emit            = (in_row_r >= bmf_pkg::POS_BITS'(2)) ||
                      ((in_row_r == bmf_pkg::POS_BITS'(1)) && (in_col_r != '0));
    col_inc         = in_col_r + bmf_pkg::POS_BITS'(1);
    out_col_inc     = out_col_r + bmf_pkg::POS_BITS'(1);
    cur_flags.left  = out_col_r != '0;
    cur_flags.right = out_col_inc < frame_width_r;
    cur_flags.up    = out_row_r != '0;
    cur_flags.down  = (out_row_r + bmf_pkg::POS_BITS'(1)) < frame_height_r;
    cur_flags.last  = !cur_flags.right && !cur_flags.down;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (keep) begin
      if (col_inc >= frame_width_r) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + bmf_pkg::POS_BITS'(1);
      end else begin
        in_col_nxt = col_inc;
      end
      if (emit) begin
        if (cur_flags.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_inc >= frame_width_r) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + bmf_pkg::POS_BITS'(1);
        end else begin
          out_col_nxt = out_col_inc;
        end
      end
    end
    if (cfg_wr_en) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------- stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_free) begin
      a_valid_r <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_sample_r <= pixel_phase ? in_pixel_value : '0;
      a_col_r    <= AW'(in_col_r);
      a_emit_r   <= emit;
      a_flags_r  <= cur_flags;
    end
  end

  // ---------------------------------------------------------------- row stores
  assign lb_ctl.rd_en = keep;
  assign lb_ctl.wr_en = a_move;

  bmf_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_buf (
    .clk      (clk),
    .ctl      (lb_ctl),
    .rd_addr  (AW'(in_col_r)),
    .wr_addr  (a_col_r),
    .wr_upper (lb_rd_lower),
    .wr_lower (a_sample_r),
    .rd_upper (lb_rd_upper),
    .rd_lower (lb_rd_lower)
  );

  // ---------------------------------------------------------------- window, stage B
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (a_move) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= lb_rd_upper;
      win_r[1][2] <= lb_rd_lower;
      win_r[2][2] <= a_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_free) begin
      b_valid_r <= a_valid_r && a_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_flags_r <= a_flags_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = 18'(win_r[r][1]) +
                   (b_flags_r.left  ? 18'(win_r[r][0]) : 18'sd0) +
                   (b_flags_r.right ? 18'(win_r[r][2]) : 18'sd0);
    end
  end

  // ---------------------------------------------------------------- stage C
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_free) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free) begin
      c_row_r   <= row_sum;
      c_flags_r <= b_flags_r;
    end
  end

  always_comb begin
    total  = 20'(c_row_r[1]) +
             (c_flags_r.up   ? 20'(c_row_r[0]) : 20'sd0) +
             (c_flags_r.down ? 20'(c_row_r[2]) : 20'sd0);
    mag    = total[19] ? 19'(-total) : 19'(total);
    n_rows = 2'd1 + 2'(c_flags_r.up) + 2'(c_flags_r.down);
    n_cols = 2'd1 + 2'(c_flags_r.left) + 2'(c_flags_r.right);
    n_cnt  = 4'(n_rows) * 4'(n_cols);
    x_val  = {mag, 1'b0} + 20'(n_cnt);
    unique case (n_cnt)
      4'd2, 4'd6: y_val = 19'(x_val >> 2);
      4'd4:       y_val = 19'(x_val >> 3);
      default:    y_val = 19'(x_val >> 1);
    endcase
  end

  // ---------------------------------------------------------------- stage D
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (d_free) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_free) begin
      d_y_r    <= y_val;
      d_n_r    <= n_cnt;
      d_neg_r  <= total[19];
      d_last_r <= c_flags_r.last;
    end
  end

  always_comb begin
    unique case (d_n_r)
      4'd3, 4'd6: begin
        mult = bmf_pkg::RECIP3;
        sh   = 5'(bmf_pkg::RECIP3_SHIFT);
      end
      4'd9: begin
        mult = bmf_pkg::RECIP9;
        sh   = 5'(bmf_pkg::RECIP9_SHIFT);
      end
      default: begin
        mult = 20'd1;
        sh   = 5'd0;
      end
    endcase
    prod     = 39'(d_y_r) * 39'(mult);
    q_val    = 17'(prod >> sh);
    mean_val = d_neg_r ? (17'd0 - q_val) : q_val;
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_mean_value_r <= mean_val[15:0];
      out_frame_last_r <= d_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_value_r;
  assign out_frame_last = out_frame_last_r;

  // ---------------------------------------------------------------- checks
  a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !c_free) |=> $stable(win_r))
    else $error("window shifted under a stalled neighborhood");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (keep && emit && cur_flags.last) |=>
      (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0))
    else $error("counters not cleared after last pixel of frame");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_col_r < frame_width_r) && (out_col_r < frame_width_r) &&
    (out_row_r < frame_height_r))
    else $error("position counter outside frame");

endmodule

[verif/tb.sv]
// Self-checking bench for box_mean_3x3_filter: a directed table, then random frames
// with gaps and stalls on both sides, checked against an in-bench 3x3 mean predictor.
// Depends on bmf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_W          = 1024;
  localparam int SETTLE         = 10;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int WIDE_FRAME     = 2;
  localparam int WIDE_EXTRA     = 33;
  localparam int TALL_FRAME     = 5;
  localparam int TALL_CUT       = 200;
  localparam int PRESSURE_FRAME = 8;
  localparam int PAUSE_FRAME    = 11;
  localparam longint TIMEOUT_NS = 5_000_000;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;
  localparam bmf_pkg::sample_t MAX_S = 16'sh7FFF;
  localparam bmf_pkg::sample_t MIN_S = 16'sh8000;

  typedef logic [bmf_pkg::CFG_DATA_BITS-1:0] cfg_word_t;
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    bmf_pkg::sample_t mean;
    logic             last;
  } mean_res_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [bmf_pkg::CFG_INDEX_BITS-1:0] reg_idx;
    cfg_word_t                          reg_val;
    logic                               act;
    bmf_pkg::sample_t                   px;
    logic                               typed;
    bmf_pkg::sample_t                   exp_mean;
    logic                               exp_last;
  } dir_row_t;

  localparam int DIR_ROWS = 28;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // zero sizes read as 1x1
    '{ROW_REG, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_REG, bmf_pkg::REG_FRAME_HEIGHT, 11'd0, ACT_PIXEL, 16'sd0, 1'b0, 16'sd0, 1'b0},
    // flush before the pixel is dropped, pixel after it acts as flush
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_FLUSH, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, MAX_S, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, -16'sd1234, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_FLUSH, 16'sd0, 1'b1, MAX_S, 1'b1},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, MIN_S, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_FLUSH, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_FLUSH, 16'sd0, 1'b1, MIN_S, 1'b1},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, 16'sh2AAA, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_FLUSH, 16'sd0, 1'b1, 16'sd0, 1'b1},
    // partial frame, dropped by the next write
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, 16'sd100, 1'b0, 16'sd0, 1'b0},
    '{ROW_REG, bmf_pkg::REG_FRAME_WIDTH, 11'd3, ACT_PIXEL, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_REG, bmf_pkg::REG_FRAME_HEIGHT, 11'd3, ACT_PIXEL, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, MAX_S, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, MAX_S, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, MAX_S, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, MAX_S, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, MAX_S, 1'b1, MAX_S, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, MAX_S, 1'b1, MAX_S, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, MAX_S, 1'b1, MAX_S, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, MAX_S, 1'b1, MAX_S, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_PIXEL, MAX_S, 1'b1, MAX_S, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_FLUSH, 16'sd0, 1'b1, MAX_S, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_FLUSH, 16'sd0, 1'b1, MAX_S, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_FLUSH, 16'sd0, 1'b1, MAX_S, 1'b0},
    '{ROW_ITEM, bmf_pkg::REG_FRAME_WIDTH, 11'd0, ACT_FLUSH, 16'sd0, 1'b1, MAX_S, 1'b1}
  };

  logic                               clk            = 1'b0;
  logic                               rst_n          = 1'b0;
  logic                               in_valid       = 1'b0;
  logic                               in_action      = ACT_PIXEL;
  bmf_pkg::sample_t                   in_pixel_value = '0;
  logic                               out_ready      = 1'b0;
  logic                               cfg_wr_en      = 1'b0;
  logic [bmf_pkg::CFG_INDEX_BITS-1:0] cfg_index      = bmf_pkg::REG_FRAME_WIDTH;
  cfg_word_t                          cfg_data       = '0;
  logic                               in_ready;
  logic                               out_valid;
  bmf_pkg::sample_t                   out_mean_value;
  logic                               out_frame_last;

  // predictor state
  int unsigned      cur_width, cur_height;
  bmf_pkg::sample_t prev2_row [MAX_W];
  bmf_pkg::sample_t prev1_row [MAX_W];
  bmf_pkg::sample_t nbhd [9];
  int unsigned      feed_col, feed_row, pix_col, pix_row;

  mean_res_t   mean_q [$];
  int unsigned err_count    = 0;
  int unsigned items_done   = 0;
  int unsigned results_seen = 0;
  int unsigned widest       = 0;
  int unsigned tallest      = 0;
  bit          burst        = 1'b0;
  bit          hold_req     = 1'b0;

  box_mean_3x3_filter #(.MAX_WIDTH(MAX_W)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mean_value (out_mean_value),
    .out_frame_last (out_frame_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial forever #1 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bmf_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return MAX_S;
      1: return MIN_S;
      2: return bmf_pkg::sample_t'(int'($urandom_range(0, 6)) - 3);
      default: return bmf_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic void restart_counters();
    feed_col = 0;
    feed_row = 0;
    pix_col  = 0;
    pix_row  = 0;
  endfunction

  // one input item; returns 1 when it completes a pixel
  function automatic bit box_mean_step(input logic act, input bmf_pkg::sample_t px,
                                       output bit dropped, output mean_res_t res);
    bmf_pkg::sample_t smp;
    bit               fires, lf, rt, up, dn;
    int               sum, n, mag, q;
    dropped = 1'b0;
    res     = '0;
    smp     = '0;
    if (feed_row < cur_height) begin
      if (act == ACT_FLUSH) begin
        dropped = 1'b1;
        return 1'b0;
      end
      smp = px;
    end
    fires = (feed_row >= 2) || (feed_row == 1 && feed_col >= 1);
    for (int r = 0; r < 3; r++) begin
      nbhd[r*3]   = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = prev2_row[feed_col];
    nbhd[5] = prev1_row[feed_col];
    nbhd[8] = smp;
    prev2_row[feed_col] = prev1_row[feed_col];
    prev1_row[feed_col] = smp;
    feed_col++;
    if (feed_col >= cur_width) begin
      feed_col = 0;
      feed_row++;
    end
    if (!fires) return 1'b0;

    lf = pix_col > 0;
    rt = pix_col + 1 < cur_width;
    up = pix_row > 0;
    dn = pix_row + 1 < cur_height;
    res.last = (pix_row + 1 >= cur_height) && (pix_col + 1 >= cur_width);
    sum = 0;
    n   = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((r == 0 && !up) || (r == 2 && !dn) || (c == 0 && !lf) || (c == 2 && !rt))) begin
          sum += nbhd[r*3+c];
          n++;
        end
      end
    end
    mag = (sum < 0) ? -sum : sum;
    q   = (2 * mag + n) / (2 * n);
    res.mean = bmf_pkg::sample_t'((sum < 0) ? -q : q);
    if (res.last) begin
      restart_counters();
    end else begin
      pix_col++;
      if (pix_col >= cur_width) begin
        pix_col = 0;
        pix_row++;
      end
    end
    return 1'b1;
  endfunction

  // hold input idle until every expected result is in, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // sel[0] writes frame_width, sel[1] writes frame_height
  task automatic reconfigure(input logic [1:0] sel, input cfg_word_t w_val, input cfg_word_t h_val);
    int unsigned v;
    drain_results();
    for (int i = 0; i < 2; i++) begin
      if (sel[i]) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= (i == 0) ? bmf_pkg::REG_FRAME_WIDTH : bmf_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= (i == 0) ? w_val : h_val;
        @(posedge clk);
        v = (i == 0) ? w_val : h_val;
        if (v == 0) v = 1;
        if (i == 0) begin
          if (v > MAX_W) v = MAX_W;
          cur_width = v;
          if (v > widest) widest = v;
        end else begin
          if (v > bmf_pkg::HEIGHT_LIMIT) v = bmf_pkg::HEIGHT_LIMIT;
          cur_height = v;
          if (v > tallest) tallest = v;
        end
        restart_counters();
      end
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic offer(input logic act, input bmf_pkg::sample_t px, input bit typed,
                       input mean_res_t typed_res);
    int unsigned g;
    bit          fired, dropped;
    mean_res_t   res;
    g = burst ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_pixel_value <= px;
    do @(posedge clk); while (!in_ready);
    fired = box_mean_step(act, px, dropped, res);
    if (!dropped) items_done++;
    if (typed) begin
      mean_q.push_back(typed_res);
    end else if (fired) begin
      mean_q.push_back(res);
    end
  endtask

  initial begin : result_monitor
    int unsigned hold_left, stall_left, flip_left;
    bit          free_run;
    mean_res_t   want;
    hold_left  = 0;
    stall_left = 0;
    flip_left  = 500;
    free_run   = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (mean_q.size() == 0) begin
          $error("unexpected transfer: mean_value %0d frame_last %0b",
                 out_mean_value, out_frame_last);
          err_count++;
        end else begin
          want = mean_q.pop_front();
          results_seen++;
          if (out_mean_value !== want.mean) begin
            $error("mean_value: expected %0d, got %0d", want.mean, out_mean_value);
            err_count++;
          end
          if (out_frame_last !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, out_frame_last);
            err_count++;
          end
        end
      end
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      flip_left--;
      if (flip_left == 0) begin
        free_run  = !free_run;
        flip_left = $urandom_range(200, 800);
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!free_run && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int unsigned frame_no, frame_items, n_pix, n_all, cut_at, pause_at, k, r;
    logic [1:0]  sel;
    cfg_word_t   w_val, h_val;
    bit          must_write;

    cur_width  = bmf_pkg::RESET_SIZE;
    cur_height = bmf_pkg::RESET_SIZE;
    for (int i = 0; i < MAX_W; i++) begin
      prev2_row[i] = '0;
      prev1_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) nbhd[i] = '0;
    restart_counters();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].kind == ROW_REG) begin
        reconfigure((DIR_TAB[i].reg_idx == bmf_pkg::REG_FRAME_WIDTH) ? 2'b01 : 2'b10,
                    DIR_TAB[i].reg_val, DIR_TAB[i].reg_val);
      end else begin
        offer(DIR_TAB[i].act, DIR_TAB[i].px, DIR_TAB[i].typed,
              mean_res_t'{DIR_TAB[i].exp_mean, DIR_TAB[i].exp_last});
      end
    end

    frame_no    = 0;
    frame_items = 0;
    must_write  = 1'b0;
    while (frame_items < RANDOM_ITEMS || frame_no <= PAUSE_FRAME) begin
      sel   = 2'b00;
      w_val = '0;
      h_val = '0;
      if (frame_no == WIDE_FRAME) begin
        sel = 2'b11; w_val = 11'd2047; h_val = 11'd0;
      end else if (frame_no == TALL_FRAME) begin
        sel = 2'b11; w_val = 11'd1; h_val = 11'd1024;
      end else if (frame_no == PRESSURE_FRAME) begin
        sel = 2'b11; w_val = 11'd8; h_val = 11'd40;
      end else begin
        sel[0] = (cur_width > 200) || ($urandom_range(0, 9) < 6);
        sel[1] = (cur_height > 20) || ($urandom_range(0, 9) < 6);
        if (must_write && sel == 2'b00) sel[0] = 1'b1;
        r = $urandom_range(0, 99);
        w_val = (r < 65) ? cfg_word_t'($urandom_range(1, 6)) :
                (r < 90) ? cfg_word_t'($urandom_range(7, 40)) :
                (r < 97) ? cfg_word_t'($urandom_range(41, 200)) : cfg_word_t'(0);
        r = $urandom_range(0, 99);
        h_val = (r < 70) ? cfg_word_t'($urandom_range(1, 6)) :
                (r < 95) ? cfg_word_t'($urandom_range(7, 20)) : cfg_word_t'(0);
      end
      if (sel != 2'b00) reconfigure(sel, w_val, h_val);

      n_pix    = cur_width * cur_height;
      n_all    = n_pix + cur_width + 1;
      burst    = (frame_no == PRESSURE_FRAME) || ($urandom_range(0, 3) == 0);
      cut_at   = ($urandom_range(0, 11) == 0) ? $urandom_range(0, n_all - 1) : n_all;
      if (frame_no == WIDE_FRAME) begin
        cut_at = cur_width + WIDE_EXTRA;
      end else if (frame_no == TALL_FRAME) begin
        cut_at = TALL_CUT;
      end
      pause_at = (frame_no == PAUSE_FRAME || $urandom_range(0, 29) == 0) ?
                 $urandom_range(1, n_all - 1) : n_all;
      must_write = cut_at < n_all;
      if (frame_no == PRESSURE_FRAME) hold_req = 1'b1;

      k = 0;
      while (k < cut_at) begin
        if (k < n_pix && $urandom_range(0, 19) == 0) begin
          offer(ACT_FLUSH, pick_sample(), 1'b0, '0);
        end else begin
          offer((k >= n_pix && $urandom_range(0, 2) != 0) ? ACT_FLUSH : ACT_PIXEL,
                pick_sample(), 1'b0, '0);
          k++;
          if (k == pause_at) drain_results();
        end
      end
      frame_items += k;
      frame_no++;
    end
    burst = 1'b0;

    drain_results();
    $display("Covered %0d items in %0d random frames plus a directed table; widths to %0d,",
             items_done, frame_no, widest);
    $display("heights to %0d, %0d results compared.", tallest, results_seen);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bmf_pkg.sv
rtl/bmf_line_buf.sv
rtl/box_mean_3x3_filter.sv
verif/tb.sv
